### rtl/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg
// Word types, opcode codes and operation codes for the 6502 register/ALU
// execute block.
// ----------------------------------------------------------------------------
package c6502_pkg;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] write_data;
    logic       write_enable;
    logic [7:0] acc_value;
    logic [7:0] x_value;
    logic [7:0] y_value;
    logic [7:0] status_byte;
    logic [7:0] stack_value;
    logic       branch_taken;
    logic       unknown_op;
  } res_word_t;

  // accumulator ALU group: opcode[1:0] == GRP_ALU, operation in opcode[7:5]
  localparam logic [1:0] GRP_ALU = 2'b01;

  typedef enum logic [2:0] {
    ALU_ORA = 3'd0,
    ALU_AND = 3'd1,
    ALU_EOR = 3'd2,
    ALU_ADC = 3'd3,
    ALU_STA = 3'd4,
    ALU_LDA = 3'd5,
    ALU_CMP = 3'd6,
    ALU_SBC = 3'd7
  } alu_op_t;

  typedef enum logic [2:0] {
    RMW_ASL = 3'd0,
    RMW_ROL = 3'd1,
    RMW_LSR = 3'd2,
    RMW_ROR = 3'd3,
    RMW_INC = 3'd4,
    RMW_DEC = 3'd5
  } rmw_kind_t;

  localparam logic [7:0] OP_STA_IMM = 8'h89;

  localparam logic [7:0] OP_LDX_I  = 8'hA2, OP_LDX_Z  = 8'hA6, OP_LDX_ZY = 8'hB6;
  localparam logic [7:0] OP_LDX_A  = 8'hAE, OP_LDX_AY = 8'hBE;
  localparam logic [7:0] OP_LDY_I  = 8'hA0, OP_LDY_Z  = 8'hA4, OP_LDY_ZX = 8'hB4;
  localparam logic [7:0] OP_LDY_A  = 8'hAC, OP_LDY_AX = 8'hBC;
  localparam logic [7:0] OP_STX_Z  = 8'h86, OP_STX_ZY = 8'h96, OP_STX_A  = 8'h8E;
  localparam logic [7:0] OP_STY_Z  = 8'h84, OP_STY_ZX = 8'h94, OP_STY_A  = 8'h8C;

  localparam logic [7:0] OP_TAX = 8'hAA, OP_TAY = 8'hA8, OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TYA = 8'h98, OP_TSX = 8'hBA, OP_TXS = 8'h9A;
  localparam logic [7:0] OP_PHA = 8'h48, OP_PHP = 8'h08, OP_PLA = 8'h68;
  localparam logic [7:0] OP_PLP = 8'h28;

  localparam logic [7:0] OP_BIT_Z = 8'h24, OP_BIT_A = 8'h2C;
  localparam logic [7:0] OP_CPX_I = 8'hE0, OP_CPX_Z = 8'hE4, OP_CPX_A = 8'hEC;
  localparam logic [7:0] OP_CPY_I = 8'hC0, OP_CPY_Z = 8'hC4, OP_CPY_A = 8'hCC;

  localparam logic [7:0] OP_INX = 8'hE8, OP_INY = 8'hC8;
  localparam logic [7:0] OP_DEX = 8'hCA, OP_DEY = 8'h88;

  localparam logic [7:0] OP_ASL_ACC = 8'h0A, OP_ROL_ACC = 8'h2A;
  localparam logic [7:0] OP_LSR_ACC = 8'h4A, OP_ROR_ACC = 8'h6A;

  localparam logic [7:0] OP_ASL_Z = 8'h06, OP_ASL_ZX = 8'h16, OP_ASL_A = 8'h0E, OP_ASL_AX = 8'h1E;
  localparam logic [7:0] OP_ROL_Z = 8'h26, OP_ROL_ZX = 8'h36, OP_ROL_A = 8'h2E, OP_ROL_AX = 8'h3E;
  localparam logic [7:0] OP_LSR_Z = 8'h46, OP_LSR_ZX = 8'h56, OP_LSR_A = 8'h4E, OP_LSR_AX = 8'h5E;
  localparam logic [7:0] OP_ROR_Z = 8'h66, OP_ROR_ZX = 8'h76, OP_ROR_A = 8'h6E, OP_ROR_AX = 8'h7E;
  localparam logic [7:0] OP_INC_Z = 8'hE6, OP_INC_ZX = 8'hF6, OP_INC_A = 8'hEE, OP_INC_AX = 8'hFE;
  localparam logic [7:0] OP_DEC_Z = 8'hC6, OP_DEC_ZX = 8'hD6, OP_DEC_A = 8'hCE, OP_DEC_AX = 8'hDE;

  localparam logic [7:0] OP_BPL = 8'h10, OP_BMI = 8'h30, OP_BVC = 8'h50, OP_BVS = 8'h70;
  localparam logic [7:0] OP_BCC = 8'h90, OP_BCS = 8'hB0, OP_BNE = 8'hD0, OP_BEQ = 8'hF0;

  localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLI = 8'h58, OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8, OP_CLD = 8'hD8, OP_SED = 8'hF8, OP_NOP = 8'hEA;

  localparam logic [7:0] SP_RESET = 8'hFD;

endpackage

### rtl/c6502_ifs.sv
// ----------------------------------------------------------------------------
// c6502 channel interfaces
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface c6502_cmd_if;
  logic                 valid;
  logic                 ready;
  c6502_pkg::cmd_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface c6502_res_if;
  logic                 valid;
  logic                 ready;
  c6502_pkg::res_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/cpu6502_register_alu_execute.sv
// ----------------------------------------------------------------------------
// cpu6502_register_alu_execute
// 6502 register file, ALU and flag execute stage (binary arithmetic).
//
// cmd: one word per instruction, opcode plus the operand byte already fetched
//      by the addressing mode (immediate, memory byte or pulled stack byte).
// res: one word per instruction: write-back byte and enable, A, X, Y, status
//      (NV1-DIZC, bit 4 clear), stack pointer, branch-taken, unknown-opcode.
// A command word is captured in an input register; once the result register
// can advance, it is executed against A/X/Y/SP/flags and the result register
// is loaded. One instruction per cycle is sustained while res is ready: the
// register and flag update is a single short combinational pass.
// When res stalls, the input register holds one more word, then cmd.ready
// drops until the result register drains.
// Reset: A = X = Y = 0, SP = 0xFD, only I set; both registers empty.
// ----------------------------------------------------------------------------
module cpu6502_register_alu_execute (
  input  logic                 clk,
  input  logic                 rst,
  c6502_cmd_if.sink            cmd,
  c6502_res_if.source          res
);

  // input register
  logic                  s1_valid;
  c6502_pkg::cmd_word_t  s1_word;
  // result register
  logic                  out_valid;
  c6502_pkg::res_word_t  out_word;

  logic advance;
  logic step;

  // architectural state
  logic [7:0] acc_reg, x_reg, y_reg, stack_reg;
  logic       n_reg, v_reg, d_reg, i_reg, z_reg, c_reg;
  logic [7:0] acc_next, x_next, y_next, stack_next;
  logic       n_next, v_next, d_next, i_next, z_next, c_next;

  logic [7:0] op, m;
  logic [7:0] wd;
  logic       we, br, unk;
  logic       nz_en;
  logic [7:0] nz_val;

  c6502_pkg::alu_op_t   alu_op;
  logic [7:0]           addend;
  logic [8:0]           adc_sum;
  logic                 adc_v;
  logic [8:0]           cmp_a, cmp_x, cmp_y;
  c6502_pkg::rmw_kind_t rmw_kind;
  logic                 rmw_en;
  logic                 rmw_acc;
  logic [7:0]           rmw_src;
  logic [7:0]           rmw_res;
  logic                 rmw_c;

  assign advance   = !out_valid || res.ready;
  assign step      = s1_valid && advance;
  assign cmd.ready = !s1_valid || advance;
  assign res.valid = out_valid;
  assign res.data  = out_word;

  assign op      = s1_word.opcode;
  assign m       = s1_word.operand;
  assign alu_op  = c6502_pkg::alu_op_t'(op[7:5]);
  assign addend  = (alu_op == c6502_pkg::ALU_SBC) ? ~m : m;
  assign adc_sum = {1'b0, acc_reg} + {1'b0, addend} + {8'd0, c_reg};
  assign adc_v   = ~(acc_reg[7] ^ addend[7]) & (acc_reg[7] ^ adc_sum[7]);
  assign cmp_a   = {1'b0, acc_reg} - {1'b0, m};
  assign cmp_x   = {1'b0, x_reg} - {1'b0, m};
  assign cmp_y   = {1'b0, y_reg} - {1'b0, m};
  assign rmw_src = rmw_acc ? acc_reg : m;

  // shift / rotate / inc / dec unit
  always_comb begin
    rmw_c = c_reg;
    case (rmw_kind)
      c6502_pkg::RMW_ASL: begin
        rmw_res = {rmw_src[6:0], 1'b0};
        rmw_c   = rmw_src[7];
      end
      c6502_pkg::RMW_ROL: begin
        rmw_res = {rmw_src[6:0], c_reg};
        rmw_c   = rmw_src[7];
      end
      c6502_pkg::RMW_LSR: begin
        rmw_res = {1'b0, rmw_src[7:1]};
        rmw_c   = rmw_src[0];
      end
      c6502_pkg::RMW_ROR: begin
        rmw_res = {c_reg, rmw_src[7:1]};
        rmw_c   = rmw_src[0];
      end
      c6502_pkg::RMW_INC: rmw_res = rmw_src + 8'd1;
      c6502_pkg::RMW_DEC: rmw_res = rmw_src - 8'd1;
      default:            rmw_res = rmw_src;
    endcase
  end

  // opcode decode and state update
  always_comb begin
    acc_next   = acc_reg;
    x_next     = x_reg;
    y_next     = y_reg;
    stack_next = stack_reg;
    n_next     = n_reg;
    v_next     = v_reg;
    d_next     = d_reg;
    i_next     = i_reg;
    z_next     = z_reg;
    c_next     = c_reg;
    wd         = 8'd0;
    we         = 1'b0;
    br         = 1'b0;
    unk        = 1'b0;
    nz_en      = 1'b0;
    nz_val     = 8'd0;
    rmw_en     = 1'b0;
    rmw_acc    = 1'b0;
    rmw_kind   = c6502_pkg::RMW_ASL;

    if (op[1:0] == c6502_pkg::GRP_ALU) begin
      if (op == c6502_pkg::OP_STA_IMM) begin
        unk = 1'b1;
      end else begin
        case (alu_op)
          c6502_pkg::ALU_ORA: begin
            acc_next = acc_reg | m;
            nz_en = 1'b1; nz_val = acc_next;
          end
          c6502_pkg::ALU_AND: begin
            acc_next = acc_reg & m;
            nz_en = 1'b1; nz_val = acc_next;
          end
          c6502_pkg::ALU_EOR: begin
            acc_next = acc_reg ^ m;
            nz_en = 1'b1; nz_val = acc_next;
          end
          c6502_pkg::ALU_ADC, c6502_pkg::ALU_SBC: begin
            acc_next = adc_sum[7:0];
            c_next   = adc_sum[8];
            v_next   = adc_v;
            nz_en = 1'b1; nz_val = acc_next;
          end
          c6502_pkg::ALU_STA: begin
            wd = acc_reg; we = 1'b1;
          end
          c6502_pkg::ALU_LDA: begin
            acc_next = m;
            nz_en = 1'b1; nz_val = m;
          end
          c6502_pkg::ALU_CMP: begin
            c_next = ~cmp_a[8];
            nz_en = 1'b1; nz_val = cmp_a[7:0];
          end
          default: begin
            unk = 1'b1;
          end
        endcase
      end
    end else begin
      case (op)
        c6502_pkg::OP_LDX_I, c6502_pkg::OP_LDX_Z, c6502_pkg::OP_LDX_ZY,
        c6502_pkg::OP_LDX_A, c6502_pkg::OP_LDX_AY: begin
          x_next = m; nz_en = 1'b1; nz_val = m;
        end
        c6502_pkg::OP_LDY_I, c6502_pkg::OP_LDY_Z, c6502_pkg::OP_LDY_ZX,
        c6502_pkg::OP_LDY_A, c6502_pkg::OP_LDY_AX: begin
          y_next = m; nz_en = 1'b1; nz_val = m;
        end
        c6502_pkg::OP_STX_Z, c6502_pkg::OP_STX_ZY, c6502_pkg::OP_STX_A: begin
          wd = x_reg; we = 1'b1;
        end
        c6502_pkg::OP_STY_Z, c6502_pkg::OP_STY_ZX, c6502_pkg::OP_STY_A: begin
          wd = y_reg; we = 1'b1;
        end
        c6502_pkg::OP_TAX: begin
          x_next = acc_reg; nz_en = 1'b1; nz_val = acc_reg;
        end
        c6502_pkg::OP_TAY: begin
          y_next = acc_reg; nz_en = 1'b1; nz_val = acc_reg;
        end
        c6502_pkg::OP_TXA: begin
          acc_next = x_reg; nz_en = 1'b1; nz_val = x_reg;
        end
        c6502_pkg::OP_TYA: begin
          acc_next = y_reg; nz_en = 1'b1; nz_val = y_reg;
        end
        c6502_pkg::OP_TSX: begin
          x_next = stack_reg; nz_en = 1'b1; nz_val = stack_reg;
        end
        c6502_pkg::OP_TXS: stack_next = x_reg;
        c6502_pkg::OP_PHA: begin
          wd = acc_reg; we = 1'b1; stack_next = stack_reg - 8'd1;
        end
        c6502_pkg::OP_PHP: begin
          // pushed copy has break and bit 5 set
          wd = {n_reg, v_reg, 1'b1, 1'b1, d_reg, i_reg, z_reg, c_reg};
          we = 1'b1;
          stack_next = stack_reg - 8'd1;
        end
        c6502_pkg::OP_PLA: begin
          acc_next = m; nz_en = 1'b1; nz_val = m;
          stack_next = stack_reg + 8'd1;
        end
        c6502_pkg::OP_PLP: begin
          n_next = m[7]; v_next = m[6]; d_next = m[3];
          i_next = m[2]; z_next = m[1]; c_next = m[0];
          stack_next = stack_reg + 8'd1;
        end
        c6502_pkg::OP_BIT_Z, c6502_pkg::OP_BIT_A: begin
          z_next = ((acc_reg & m) == 8'd0);
          v_next = m[6];
          n_next = m[7];
        end
        c6502_pkg::OP_CPX_I, c6502_pkg::OP_CPX_Z, c6502_pkg::OP_CPX_A: begin
          c_next = ~cmp_x[8]; nz_en = 1'b1; nz_val = cmp_x[7:0];
        end
        c6502_pkg::OP_CPY_I, c6502_pkg::OP_CPY_Z, c6502_pkg::OP_CPY_A: begin
          c_next = ~cmp_y[8]; nz_en = 1'b1; nz_val = cmp_y[7:0];
        end
        c6502_pkg::OP_INX: begin
          x_next = x_reg + 8'd1; nz_en = 1'b1; nz_val = x_next;
        end
        c6502_pkg::OP_INY: begin
          y_next = y_reg + 8'd1; nz_en = 1'b1; nz_val = y_next;
        end
        c6502_pkg::OP_DEX: begin
          x_next = x_reg - 8'd1; nz_en = 1'b1; nz_val = x_next;
        end
        c6502_pkg::OP_DEY: begin
          y_next = y_reg - 8'd1; nz_en = 1'b1; nz_val = y_next;
        end
        c6502_pkg::OP_ASL_ACC: begin
          rmw_acc = 1'b1; rmw_kind = c6502_pkg::RMW_ASL;
        end
        c6502_pkg::OP_ROL_ACC: begin
          rmw_acc = 1'b1; rmw_kind = c6502_pkg::RMW_ROL;
        end
        c6502_pkg::OP_LSR_ACC: begin
          rmw_acc = 1'b1; rmw_kind = c6502_pkg::RMW_LSR;
        end
        c6502_pkg::OP_ROR_ACC: begin
          rmw_acc = 1'b1; rmw_kind = c6502_pkg::RMW_ROR;
        end
        c6502_pkg::OP_ASL_Z, c6502_pkg::OP_ASL_ZX, c6502_pkg::OP_ASL_A, c6502_pkg::OP_ASL_AX: begin
          rmw_en = 1'b1; rmw_kind = c6502_pkg::RMW_ASL;
        end
        c6502_pkg::OP_ROL_Z, c6502_pkg::OP_ROL_ZX, c6502_pkg::OP_ROL_A, c6502_pkg::OP_ROL_AX: begin
          rmw_en = 1'b1; rmw_kind = c6502_pkg::RMW_ROL;
        end
        c6502_pkg::OP_LSR_Z, c6502_pkg::OP_LSR_ZX, c6502_pkg::OP_LSR_A, c6502_pkg::OP_LSR_AX: begin
          rmw_en = 1'b1; rmw_kind = c6502_pkg::RMW_LSR;
        end
        c6502_pkg::OP_ROR_Z, c6502_pkg::OP_ROR_ZX, c6502_pkg::OP_ROR_A, c6502_pkg::OP_ROR_AX: begin
          rmw_en = 1'b1; rmw_kind = c6502_pkg::RMW_ROR;
        end
        c6502_pkg::OP_INC_Z, c6502_pkg::OP_INC_ZX, c6502_pkg::OP_INC_A, c6502_pkg::OP_INC_AX: begin
          rmw_en = 1'b1; rmw_kind = c6502_pkg::RMW_INC;
        end
        c6502_pkg::OP_DEC_Z, c6502_pkg::OP_DEC_ZX, c6502_pkg::OP_DEC_A, c6502_pkg::OP_DEC_AX: begin
          rmw_en = 1'b1; rmw_kind = c6502_pkg::RMW_DEC;
        end
        c6502_pkg::OP_BPL: br = ~n_reg;
        c6502_pkg::OP_BMI: br = n_reg;
        c6502_pkg::OP_BVC: br = ~v_reg;
        c6502_pkg::OP_BVS: br = v_reg;
        c6502_pkg::OP_BCC: br = ~c_reg;
        c6502_pkg::OP_BCS: br = c_reg;
        c6502_pkg::OP_BNE: br = ~z_reg;
        c6502_pkg::OP_BEQ: br = z_reg;
        c6502_pkg::OP_CLC: c_next = 1'b0;
        c6502_pkg::OP_SEC: c_next = 1'b1;
        c6502_pkg::OP_CLI: i_next = 1'b0;
        c6502_pkg::OP_SEI: i_next = 1'b1;
        c6502_pkg::OP_CLV: v_next = 1'b0;
        c6502_pkg::OP_CLD: d_next = 1'b0;
        c6502_pkg::OP_SED: d_next = 1'b1;
        c6502_pkg::OP_NOP: ;
        default: unk = 1'b1;
      endcase
    end

    if (rmw_acc) begin
      acc_next = rmw_res;
      c_next   = rmw_c;
      nz_en = 1'b1; nz_val = rmw_res;
    end
    if (rmw_en) begin
      wd = rmw_res; we = 1'b1;
      c_next = rmw_c;
      nz_en = 1'b1; nz_val = rmw_res;
    end
    if (nz_en) begin
      n_next = nz_val[7];
      z_next = (nz_val == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc_reg   <= 8'd0;
      x_reg     <= 8'd0;
      y_reg     <= 8'd0;
      stack_reg <= c6502_pkg::SP_RESET;
      n_reg     <= 1'b0;
      v_reg     <= 1'b0;
      d_reg     <= 1'b0;
      i_reg     <= 1'b1;
      z_reg     <= 1'b0;
      c_reg     <= 1'b0;
    end else begin
      if (cmd.ready) begin
        s1_valid <= cmd.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (step) begin
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        stack_reg <= stack_next;
        n_reg     <= n_next;
        v_reg     <= v_next;
        d_reg     <= d_next;
        i_reg     <= i_next;
        z_reg     <= z_next;
        c_reg     <= c_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_word <= cmd.data;
    end
    if (step) begin
      out_word.write_data   <= wd;
      out_word.write_enable <= we;
      out_word.acc_value    <= acc_next;
      out_word.x_value      <= x_next;
      out_word.y_value      <= y_next;
      out_word.status_byte  <= {n_next, v_next, 1'b1, 1'b0, d_next, i_next, z_next, c_next};
      out_word.stack_value  <= stack_next;
      out_word.branch_taken <= br;
      out_word.unknown_op   <= unk;
    end
  end

  // unknown opcodes and branches leave the register file untouched
  a_noop_holds_state: assert property (@(posedge clk) disable iff (rst)
    (step && (unk || br)) |=> (acc_reg == $past(acc_reg) && x_reg == $past(x_reg) &&
      y_reg == $past(y_reg) && stack_reg == $past(stack_reg)))
    else $error("state changed on a no-op or branch");

  // an unknown opcode never requests a write
  a_unk_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.unknown_op && out_word.write_enable))
    else $error("write requested by unknown opcode");

  // backpressure only when both registers are full and the sink stalls
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s1_valid && out_valid && !res.ready))
    else $error("cmd.ready low without a stall");

  // result shows the state that was committed with it
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_word.acc_value == acc_reg && out_word.stack_value == stack_reg &&
      out_word.status_byte[0] == c_reg))
    else $error("result word disagrees with committed state");

endmodule
